[rtl/tpss_pkg.sv]
// Shared types and constants for the tempo pattern step sequencer.
package tpss_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int MAX_STEPS     = 256;

  localparam int IDX_W  = $clog2(PATTERN_DEPTH > 1 ? PATTERN_DEPTH : 2);
  localparam int CNT_W  = $clog2(PATTERN_DEPTH + 1);
  localparam int STEP_W = 8;
  localparam int LEN_W  = 9;
  localparam int ECNT_W = 7;
  localparam int TEMPO_W = 16;
  localparam int ACC_W  = 12;
  localparam int SUM_W  = 13;
  localparam int DELTA_W = 11;
  localparam int MASK_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SUM_W-1:0]   ACCUM_UNIT    = 13'd3600;
  localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 16'd150;
  localparam logic [TEMPO_W-1:0] TEMPO_MIN     = 16'd30;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX     = 16'd300;
  localparam int                 STEPS_SHIFT   = 2;  // four steps per beat
  localparam logic [2:0]         TOP_CHANNEL   = 3'd5;
  localparam logic [2:0]         NOISE_CH_MIN  = 3'd4;
  localparam logic [11:0]        NOISE_MASK    = 12'h01f;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPO    = 2'd0,
    CFG_SONG_LEN = 2'd1,
    CFG_ENTRIES  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  entry_index;
    logic [7:0]  entry_step;
    logic [2:0]  entry_channel;
    logic        entry_noise;
    logic [11:0] entry_period;
    logic [4:0]  entry_volume;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  step_index;
    logic [2:0]  voice_channel;
    logic        noise_mode;
    logic [11:0] voice_period;
    logic [4:0]  voice_volume;
    logic        voice_on;
    logic [5:0]  used_mask;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  step;
    logic [2:0]  channel;
    logic        noise;
    logic [11:0] period;
    logic [4:0]  volume;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/tpss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tpss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tpss_voice.sv]
// Turns one pattern entry into a voice command and flags a step match.
module tpss_voice (
  input  tpss_pkg::entry_t                 entry,
  input  logic [tpss_pkg::STEP_W-1:0]      step,
  input  logic [tpss_pkg::MASK_W-1:0]      mask_in,
  output logic                             match,
  output tpss_pkg::out_item_t              voice
);

  logic [2:0] ch;
  logic       nz;

  always_comb begin
    ch = (entry.channel > tpss_pkg::TOP_CHANNEL) ? tpss_pkg::TOP_CHANNEL : entry.channel;
    nz = entry.noise && (ch >= tpss_pkg::NOISE_CH_MIN);
    match = (entry.step == step);
    voice.step_index    = step;
    voice.voice_channel = ch;
    voice.noise_mode    = nz;
    voice.voice_period  = nz ? (entry.period & tpss_pkg::NOISE_MASK) : entry.period;
    voice.voice_volume  = entry.volume;
    voice.voice_on      = (entry.volume != 5'd0);
    voice.used_mask     = mask_in | (tpss_pkg::MASK_W'(1) << ch);
    voice.last          = 1'b0;
  end

endmodule

[rtl/tempo_pattern_step_sequencer.sv]
// Top level of the tempo pattern step sequencer: control, scan and output stage.
//
// Input channel (in_valid/in_ready/in_data) carries load, start and tick items.
// A load writes one pattern slot. A start rewinds step,
// phase and channel mask and, with a nonzero entry count, plays row 0. While playing, a tick
// adds four times the clamped tempo to the phase; on crossing 3600 the step
// advances and its row is played.
// Playing a row reads the pattern RAM one slot per cycle unless a receiver
// stall holds the scan, and an item that plays a row holds the input until
// the scan of entry_count slots (entry_count saturated to the store depth)
// and its flush are done. The single read port of the pattern RAM sets this pace.
// Each matching slot yields one voice command on out_valid/out_ready/out_data.
// One command is held back so the final one of a row carries last; a command
// moves from the held register to the output register only once the next
// matching slot or the end of the scan has been seen.
// A stalled receiver freezes the scan on a matching slot while a command is held; nothing is dropped.
// Configuration writes (cfg_valid/cfg_data at cfg_index) complete every cycle.
// Synchronous active-low reset idles the block, restores register defaults and
// clears step, phase and mask; pattern slots stay undefined until loaded.
module tempo_pattern_step_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tpss_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tpss_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tpss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [tpss_pkg::TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [tpss_pkg::LEN_W-1:0]   song_len_r, song_len_nxt;
  logic [tpss_pkg::ECNT_W-1:0]  entry_cnt_r, entry_cnt_nxt;

  // song state
  logic [tpss_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [tpss_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [tpss_pkg::MASK_W-1:0]  mask_r, mask_nxt;
  logic                         playing_r, playing_nxt;

  // scan state
  logic [tpss_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [tpss_pkg::CNT_W-1:0]   limit_r, limit_nxt;
  logic                         pend_v_r, pend_v_nxt;
  tpss_pkg::out_item_t          pend_r, pend_nxt;

  // output stage
  logic                         out_valid_r, out_valid_nxt;
  tpss_pkg::out_item_t          out_data_r, out_data_nxt;

  // pattern RAM
  logic                         ram_we;
  logic [tpss_pkg::IDX_W-1:0]   ram_raddr;
  logic [tpss_pkg::ENTRY_W-1:0] ram_rdata;
  tpss_pkg::entry_t             wr_entry;
  tpss_pkg::entry_t             rd_entry;

  logic                         match;
  tpss_pkg::out_item_t          voice;

  logic                         in_xfer;
  logic                         out_free;
  logic [tpss_pkg::CNT_W-1:0]   limit_cur;
  logic [tpss_pkg::TEMPO_W-1:0] tempo_cl;
  logic [tpss_pkg::DELTA_W-1:0] delta;
  logic [tpss_pkg::SUM_W-1:0]   acc_sum;
  logic [tpss_pkg::LEN_W-1:0]   len_cl;
  logic [tpss_pkg::LEN_W-1:0]   step_inc;
  logic                         scan_end;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign wr_entry.step    = in_data.entry_step;
  assign wr_entry.channel = in_data.entry_channel;
  assign wr_entry.noise   = in_data.entry_noise;
  assign wr_entry.period  = in_data.entry_period;
  assign wr_entry.volume  = in_data.entry_volume;
  assign rd_entry         = tpss_pkg::entry_t'(ram_rdata);

  assign ram_we = in_xfer && (in_data.action == tpss_pkg::ACT_LOAD)
               && (32'(in_data.entry_index) < tpss_pkg::PATTERN_DEPTH);

  tpss_ram #(
    .WIDTH (tpss_pkg::ENTRY_W),
    .DEPTH (tpss_pkg::PATTERN_DEPTH)
  ) u_pattern (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.entry_index[tpss_pkg::IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tpss_voice u_voice (
    .entry   (rd_entry),
    .step    (step_r),
    .mask_in (mask_r),
    .match   (match),
    .voice   (voice)
  );

  // tempo, song length and entry count saturation, phase sum, step increment and scan end
  always_comb begin
    if (tempo_r == '0) begin
      tempo_cl = tpss_pkg::TEMPO_DEFAULT;
    end else if (tempo_r < tpss_pkg::TEMPO_MIN) begin
      tempo_cl = tpss_pkg::TEMPO_MIN;
    end else if (tempo_r > tpss_pkg::TEMPO_MAX) begin
      tempo_cl = tpss_pkg::TEMPO_MAX;
    end else begin
      tempo_cl = tempo_r;
    end
    delta    = tpss_pkg::DELTA_W'(tempo_cl) << tpss_pkg::STEPS_SHIFT;
    acc_sum  = tpss_pkg::SUM_W'(acc_r) + tpss_pkg::SUM_W'(delta);
    len_cl   = (32'(song_len_r) > tpss_pkg::MAX_STEPS) ?
               tpss_pkg::LEN_W'(tpss_pkg::MAX_STEPS) : song_len_r;
    step_inc = tpss_pkg::LEN_W'(step_r) + tpss_pkg::LEN_W'(1);
    limit_cur = (32'(entry_cnt_r) > tpss_pkg::PATTERN_DEPTH) ?
                tpss_pkg::CNT_W'(tpss_pkg::PATTERN_DEPTH) : tpss_pkg::CNT_W'(entry_cnt_r);
    scan_end = ((tpss_pkg::CNT_W'(idx_r) + tpss_pkg::CNT_W'(1)) == limit_r);
  end

  always_comb begin
    state_nxt     = state_r;
    tempo_nxt     = tempo_r;
    song_len_nxt  = song_len_r;
    entry_cnt_nxt = entry_cnt_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    mask_nxt      = mask_r;
    playing_nxt   = playing_r;
    idx_nxt       = idx_r;
    limit_nxt     = limit_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_raddr     = '0;

    if (cfg_valid) begin
      case (cfg_index)
        tpss_pkg::CFG_TEMPO:    tempo_nxt     = cfg_data;
        tpss_pkg::CFG_SONG_LEN: song_len_nxt  = cfg_data[tpss_pkg::LEN_W-1:0];
        tpss_pkg::CFG_ENTRIES:  entry_cnt_nxt = cfg_data[tpss_pkg::ECNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        // slot 0 is read every idle cycle so a row starts with data in hand
        idx_nxt   = '0;
        limit_nxt = limit_cur;
        if (in_xfer) begin
          case (in_data.action)
            tpss_pkg::ACT_START: begin
              step_nxt    = '0;
              acc_nxt     = '0;
              mask_nxt    = '0;
              playing_nxt = (limit_cur != '0);
              if (limit_cur != '0) begin
                state_nxt = S_SCAN;
              end
            end
            tpss_pkg::ACT_TICK: begin
              if (playing_r) begin
                if (acc_sum < tpss_pkg::ACCUM_UNIT) begin
                  acc_nxt = acc_sum[tpss_pkg::ACC_W-1:0];
                end else begin
                  acc_nxt   = tpss_pkg::ACC_W'(acc_sum - tpss_pkg::ACCUM_UNIT);
                  step_nxt  = (step_inc >= len_cl) ? '0 : step_inc[tpss_pkg::STEP_W-1:0];
                  // entry count cleared while armed: the step moves, no row to scan
                  if (limit_cur != '0) begin
                    state_nxt = S_SCAN;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // a match with a command already held must push that one out first
        if (match && pend_v_r && !out_free) begin
          ram_raddr = idx_r;
        end else begin
          ram_raddr = idx_r + tpss_pkg::IDX_W'(1);
          idx_nxt   = idx_r + tpss_pkg::IDX_W'(1);
          if (match) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pend_r;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = voice;
            mask_nxt   = voice.used_mask;
          end
          if (scan_end) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
          pend_v_nxt        = 1'b0;
          state_nxt         = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tempo_r     <= tpss_pkg::TEMPO_DEFAULT;
      song_len_r  <= tpss_pkg::LEN_W'(16);
      entry_cnt_r <= '0;
      step_r      <= '0;
      acc_r       <= '0;
      mask_r      <= '0;
      playing_r   <= 1'b0;
      idx_r       <= '0;
      limit_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tempo_r     <= tempo_nxt;
      song_len_r  <= song_len_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      step_r      <= step_nxt;
      acc_r       <= acc_nxt;
      mask_r      <= mask_nxt;
      playing_r   <= playing_nxt;
      idx_r       <= idx_nxt;
      limit_r     <= limit_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  // held command never survives into idle
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_v_r)
    else $error("pending command left when idle");

  // a row is only scanned while the song is armed
  a_scan_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> playing_r)
    else $error("row scan while not playing");

  // phase stays below one step unit
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    tpss_pkg::SUM_W'(acc_r) < tpss_pkg::ACCUM_UNIT)
    else $error("phase accumulator out of range");

  // every command marks its own channel as used
  a_mask_has_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.used_mask[out_data_r.voice_channel])
    else $error("used mask misses command channel");

endmodule
